/* rtl/core/esc_pkg.sv */
// Shared constants and types of the connected subgraph counter.
package esc_pkg;

  localparam int unsigned MAX_VERTICES = 4096;
  localparam int unsigned MAX_EDGES    = 32768;
  localparam int unsigned MAX_SUBGRAPH = 8;

  localparam int unsigned VID_W  = 12;
  localparam int unsigned SIZE_W = 4;
  localparam int unsigned CNT_W  = 32;
  localparam int unsigned VA_W   = $clog2(MAX_VERTICES);
  localparam int unsigned EA_W   = $clog2(MAX_EDGES);
  localparam int unsigned EC_W   = EA_W + 1;
  localparam int unsigned LVL_W  = $clog2(MAX_SUBGRAPH);

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_START = 1'b1;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(3);

  typedef logic [VID_W-1:0] vid_t;
  typedef logic [EC_W-1:0]  ecnt_t;

  typedef struct packed {
    ecnt_t first;
    ecnt_t stop;
  } range_t;

  typedef struct packed {
    logic [EA_W-1:0] nbr_addr;
    logic [VA_W-1:0] rng_addr;
  } rd_req_t;

  typedef struct packed {
    vid_t   nbr_data;
    range_t rng_data;
  } rd_rsp_t;

  typedef struct packed {
    logic             idle;
    logic             done;
    logic [CNT_W-1:0] total;
    logic             saturated;
  } search_stat_t;

endpackage

/* rtl/core/esc_if.sv */
// Stream interfaces for requests, results and the size register.
interface esc_req_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  esc_pkg::vid_t      vertex_id;
  esc_pkg::vid_t      neighbour_id;
  modport source (output valid, req_type, vertex_id, neighbour_id, input ready);
  modport sink (input valid, req_type, vertex_id, neighbour_id, output ready);
endinterface

interface esc_res_if;
  logic                      valid;
  logic                      ready;
  logic [esc_pkg::CNT_W-1:0] motif_total;
  logic                      saturated;
  modport source (output valid, motif_total, saturated, input ready);
  modport sink (input valid, motif_total, saturated, output ready);
endinterface

interface esc_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [esc_pkg::SIZE_W-1:0] subgraph_size;
  modport source (output valid, subgraph_size, input ready);
  modport sink (input valid, subgraph_size, output ready);
endinterface

/* rtl/core/esc_graph_store.sv */
// Compressed adjacency store: neighbour memory, per-vertex ranges and load logic.
module esc_graph_store (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             ld_valid_i,
  input  esc_pkg::vid_t    ld_vertex_i,
  input  esc_pkg::vid_t    ld_nbr_i,
  output logic             ready_o,
  input  esc_pkg::rd_req_t rd_req_i,
  output esc_pkg::rd_rsp_t rd_rsp_o
);
  import esc_pkg::*;

  vid_t   nbr_mem [MAX_EDGES];
  range_t rng_mem [MAX_VERTICES];

  logic            clr_busy_q, clr_busy_d;
  logic [VA_W-1:0] clr_q, clr_d;
  ecnt_t           total_q, total_d;
  vid_t            last_v_q, last_v_d;
  ecnt_t           cur_start_q, cur_start_d;

  logic            ld_ok, new_vertex;
  ecnt_t           ld_start;
  logic            rng_we, nbr_we;
  logic [VA_W-1:0] rng_wa;
  range_t          rng_wd;
  vid_t            nbr_rd_q;
  range_t          rng_rd_q;

  assign ld_ok = ld_valid_i && !clr_busy_q
                 && (32'(ld_vertex_i) < MAX_VERTICES) && (32'(ld_nbr_i) < MAX_VERTICES)
                 && (total_q < EC_W'(MAX_EDGES))
                 && ((total_q == '0) || (ld_vertex_i >= last_v_q));
  assign new_vertex = (total_q == '0) || (ld_vertex_i != last_v_q);
  assign ld_start   = new_vertex ? total_q : cur_start_q;

  always_comb begin
    clr_busy_d  = clr_busy_q;
    clr_d       = clr_q;
    total_d     = total_q;
    last_v_d    = last_v_q;
    cur_start_d = cur_start_q;
    rng_we      = 1'b0;
    rng_wa      = VA_W'(ld_vertex_i);
    rng_wd      = '{first: ld_start, stop: total_q + EC_W'(1)};
    nbr_we      = 1'b0;
    if (clr_busy_q) begin
      rng_we = 1'b1;
      rng_wa = clr_q;
      rng_wd = '0;
      clr_d  = clr_q + VA_W'(1);
      if (clr_q == VA_W'(MAX_VERTICES - 1)) begin
        clr_busy_d = 1'b0;
      end
    end else if (ld_ok) begin
      rng_we      = 1'b1;
      nbr_we      = 1'b1;
      total_d     = total_q + EC_W'(1);
      last_v_d    = ld_vertex_i;
      cur_start_d = ld_start;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q  <= 1'b1;
      clr_q       <= '0;
      total_q     <= '0;
      last_v_q    <= '0;
      cur_start_q <= '0;
    end else begin
      clr_busy_q  <= clr_busy_d;
      clr_q       <= clr_d;
      total_q     <= total_d;
      last_v_q    <= last_v_d;
      cur_start_q <= cur_start_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (nbr_we) begin
      nbr_mem[total_q[EA_W-1:0]] <= ld_nbr_i;
    end
    nbr_rd_q <= nbr_mem[rd_req_i.nbr_addr];
  end

  always_ff @(posedge clk_i) begin
    if (rng_we) begin
      rng_mem[rng_wa] <= rng_wd;
    end
    rng_rd_q <= rng_mem[rd_req_i.rng_addr];
  end

  assign ready_o  = !clr_busy_q;
  assign rd_rsp_o = '{nbr_data: nbr_rd_q, rng_data: rng_rd_q};

endmodule

/* rtl/core/esc_search.sv */
// ESU search sequencer with the extension stack and neighbour mark memories.
module esc_search (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [esc_pkg::SIZE_W-1:0] size_i,
  input  logic                       slot_free_i,
  output esc_pkg::search_stat_t      stat_o,
  output esc_pkg::rd_req_t           rd_req_o,
  input  esc_pkg::rd_rsp_t           rd_rsp_i
);
  import esc_pkg::*;

  typedef enum logic [20:0] {
    ST_CLEAR    = 21'h000001,
    ST_IDLE     = 21'h000002,
    ST_ROOT_RD  = 21'h000004,
    ST_ROOT_CHK = 21'h000008,
    ST_NEXT     = 21'h000010,
    ST_SCAN_A   = 21'h000020,
    ST_SCAN_B   = 21'h000040,
    ST_SCAN_C   = 21'h000080,
    ST_UNM_A    = 21'h000100,
    ST_UNM_B    = 21'h000200,
    ST_LOOP     = 21'h000400,
    ST_W        = 21'h000800,
    ST_CP_A     = 21'h001000,
    ST_CP_B     = 21'h002000,
    ST_CL_V     = 21'h004000,
    ST_CL_R     = 21'h008000,
    ST_CL_A     = 21'h010000,
    ST_CL_B     = 21'h020000,
    ST_WR_RD    = 21'h040000,
    ST_WR_CHK   = 21'h080000,
    ST_DONE     = 21'h100000
  } state_e;

  vid_t ext_mem  [MAX_EDGES];
  logic mark_mem [MAX_VERTICES];

  state_e             state_q, state_d;
  logic [VA_W-1:0]    clr_q, clr_d;
  logic [VA_W-1:0]    x_q, x_d;
  vid_t               root_q, root_d;
  vid_t               w_q, w_d;
  vid_t               u_q, u_d;
  logic [SIZE_W-1:0]  k_q, k_d;
  logic [LVL_W-1:0]   f_q, f_d;
  logic [LVL_W:0]     ci_q, ci_d;
  ecnt_t              base_q [MAX_SUBGRAPH];
  ecnt_t              base_d [MAX_SUBGRAPH];
  ecnt_t              len_q  [MAX_SUBGRAPH];
  ecnt_t              len_d  [MAX_SUBGRAPH];
  ecnt_t              rem_q  [MAX_SUBGRAPH];
  ecnt_t              rem_d  [MAX_SUBGRAPH];
  vid_t               sub_q  [MAX_SUBGRAPH];
  vid_t               sub_d  [MAX_SUBGRAPH];
  ecnt_t              nb_q, nb_d, nl_q, nl_d, fresh_q, fresh_d;
  ecnt_t              i_q, i_d, e_q, e_d, e_end_q, e_end_d, q_q, q_d;
  logic [CNT_W:0]     cnt_q, cnt_d;
  logic               mark_val_q, mark_val_d;
  logic               scan_root_q, scan_root_d;

  logic [LVL_W-1:0]   fp1;
  ecnt_t              top;
  logic               ext_we, mark_we, mark_wd, mark_rd_q;
  logic [EA_W-1:0]    ext_wa, ext_ra;
  vid_t               ext_wd, ext_rd_q;
  logic [VA_W-1:0]    mark_wa, mark_ra;
  logic [EA_W-1:0]    nbr_ra;
  logic [VA_W-1:0]    rng_ra;
  range_t             rng;

  assign fp1 = f_q + LVL_W'(1);
  assign top = nb_q + nl_q;
  assign rng = rd_rsp_i.rng_data;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    x_d         = x_q;
    root_d      = root_q;
    w_d         = w_q;
    u_d         = u_q;
    k_d         = k_q;
    f_d         = f_q;
    ci_d        = ci_q;
    base_d      = base_q;
    len_d       = len_q;
    rem_d       = rem_q;
    sub_d       = sub_q;
    nb_d        = nb_q;
    nl_d        = nl_q;
    fresh_d     = fresh_q;
    i_d         = i_q;
    e_d         = e_q;
    e_end_d     = e_end_q;
    q_d         = q_q;
    cnt_d       = cnt_q;
    mark_val_d  = mark_val_q;
    scan_root_d = scan_root_q;
    ext_we      = 1'b0;
    ext_wa      = EA_W'(top);
    ext_wd      = ext_rd_q;
    ext_ra      = '0;
    mark_we     = 1'b0;
    mark_wa     = '0;
    mark_wd     = 1'b0;
    mark_ra     = '0;
    nbr_ra      = '0;
    rng_ra      = '0;
    unique case (state_q)
      ST_CLEAR: begin
        mark_we = 1'b1;
        mark_wa = clr_q;
        clr_d   = clr_q + VA_W'(1);
        if (clr_q == VA_W'(MAX_VERTICES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          cnt_d = '0;
          x_d   = '0;
          if (size_i < SIZE_W'(2)) begin
            k_d = SIZE_W'(2);
          end else if (32'(size_i) > MAX_SUBGRAPH) begin
            k_d = SIZE_W'(MAX_SUBGRAPH);
          end else begin
            k_d = size_i;
          end
          state_d = ST_ROOT_RD;
        end
      end
      ST_ROOT_RD: begin
        rng_ra  = x_q;
        state_d = ST_ROOT_CHK;
      end
      ST_ROOT_CHK: begin
        if (rng.stop > rng.first) begin
          root_d      = VID_W'(x_q);
          e_d         = rng.first;
          e_end_d     = rng.stop;
          nb_d        = '0;
          nl_d        = '0;
          fresh_d     = '0;
          scan_root_d = 1'b1;
          state_d     = ST_SCAN_A;
        end else begin
          state_d = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (x_q == VA_W'(MAX_VERTICES - 1)) begin
          state_d = ST_DONE;
        end else begin
          x_d     = x_q + VA_W'(1);
          state_d = ST_ROOT_RD;
        end
      end
      ST_SCAN_A: begin
        if (e_q == e_end_q) begin
          if (scan_root_q) begin
            q_d     = fresh_q;
            state_d = ST_UNM_A;
          end else begin
            ci_d       = '0;
            mark_val_d = 1'b0;
            state_d    = ST_CL_V;
          end
        end else begin
          nbr_ra  = EA_W'(e_q);
          state_d = ST_SCAN_B;
        end
      end
      ST_SCAN_B: begin
        u_d     = rd_rsp_i.nbr_data;
        mark_ra = VA_W'(rd_rsp_i.nbr_data);
        state_d = ST_SCAN_C;
      end
      ST_SCAN_C: begin
        if ((u_q > root_q) && !mark_rd_q && (top < EC_W'(MAX_EDGES))) begin
          ext_we  = 1'b1;
          ext_wd  = u_q;
          mark_we = 1'b1;
          mark_wa = VA_W'(u_q);
          mark_wd = 1'b1;
          nl_d    = nl_q + EC_W'(1);
        end
        e_d     = e_q + EC_W'(1);
        state_d = ST_SCAN_A;
      end
      ST_UNM_A: begin
        if (q_q == top) begin
          if (scan_root_q) begin
            base_d[0] = '0;
            len_d[0]  = nl_q;
            rem_d[0]  = nl_q;
            sub_d[0]  = root_q;
            f_d       = '0;
          end else begin
            base_d[fp1] = nb_q;
            len_d[fp1]  = nl_q;
            rem_d[fp1]  = nl_q;
            f_d         = fp1;
          end
          state_d = ST_LOOP;
        end else begin
          ext_ra  = EA_W'(q_q);
          state_d = ST_UNM_B;
        end
      end
      ST_UNM_B: begin
        mark_we = 1'b1;
        mark_wa = VA_W'(ext_rd_q);
        q_d     = q_q + EC_W'(1);
        state_d = ST_UNM_A;
      end
      ST_LOOP: begin
        if (rem_q[f_q] == '0) begin
          if (f_q == '0) begin
            state_d = ST_NEXT;
          end else begin
            f_d = f_q - LVL_W'(1);
          end
        end else begin
          rem_d[f_q] = rem_q[f_q] - EC_W'(1);
          ext_ra     = EA_W'(base_q[f_q] + rem_q[f_q] - EC_W'(1));
          state_d    = ST_W;
        end
      end
      ST_W: begin
        w_d        = ext_rd_q;
        sub_d[fp1] = ext_rd_q;
        if ((SIZE_W'(f_q) + SIZE_W'(2)) == k_q) begin
          cnt_d = cnt_q + (CNT_W + 1)'(1);
          if (cnt_d[CNT_W]) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_LOOP;
          end
        end else begin
          nb_d    = base_q[f_q] + len_q[f_q];
          nl_d    = '0;
          i_d     = '0;
          state_d = ST_CP_A;
        end
      end
      ST_CP_A: begin
        if (i_q == rem_q[f_q]) begin
          ci_d       = '0;
          mark_val_d = 1'b1;
          state_d    = ST_CL_V;
        end else begin
          ext_ra  = EA_W'(base_q[f_q] + i_q);
          state_d = ST_CP_B;
        end
      end
      ST_CP_B: begin
        if (top < EC_W'(MAX_EDGES)) begin
          ext_we = 1'b1;
          nl_d   = nl_q + EC_W'(1);
        end
        i_d     = i_q + EC_W'(1);
        state_d = ST_CP_A;
      end
      ST_CL_V: begin
        if (ci_q == ((LVL_W + 1)'(f_q) + (LVL_W + 1)'(1))) begin
          if (mark_val_q) begin
            state_d = ST_WR_RD;
          end else begin
            q_d     = fresh_q;
            state_d = ST_UNM_A;
          end
        end else begin
          mark_we = 1'b1;
          mark_wa = VA_W'(sub_q[ci_q[LVL_W-1:0]]);
          mark_wd = mark_val_q;
          rng_ra  = VA_W'(sub_q[ci_q[LVL_W-1:0]]);
          state_d = ST_CL_R;
        end
      end
      ST_CL_R: begin
        e_d     = rng.first;
        e_end_d = rng.stop;
        state_d = ST_CL_A;
      end
      ST_CL_A: begin
        if (e_q == e_end_q) begin
          ci_d    = ci_q + (LVL_W + 1)'(1);
          state_d = ST_CL_V;
        end else begin
          nbr_ra  = EA_W'(e_q);
          state_d = ST_CL_B;
        end
      end
      ST_CL_B: begin
        mark_we = 1'b1;
        mark_wa = VA_W'(rd_rsp_i.nbr_data);
        mark_wd = mark_val_q;
        e_d     = e_q + EC_W'(1);
        state_d = ST_CL_A;
      end
      ST_WR_RD: begin
        rng_ra  = VA_W'(w_q);
        state_d = ST_WR_CHK;
      end
      ST_WR_CHK: begin
        e_d         = rng.first;
        e_end_d     = rng.stop;
        fresh_d     = top;
        scan_root_d = 1'b0;
        state_d     = ST_SCAN_A;
      end
      ST_DONE: begin
        if (slot_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      x_q         <= '0;
      root_q      <= '0;
      k_q         <= SIZE_RESET;
      f_q         <= '0;
      ci_q        <= '0;
      cnt_q       <= '0;
      mark_val_q  <= 1'b0;
      scan_root_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      x_q         <= x_d;
      root_q      <= root_d;
      k_q         <= k_d;
      f_q         <= f_d;
      ci_q        <= ci_d;
      cnt_q       <= cnt_d;
      mark_val_q  <= mark_val_d;
      scan_root_q <= scan_root_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q     <= w_d;
    u_q     <= u_d;
    base_q  <= base_d;
    len_q   <= len_d;
    rem_q   <= rem_d;
    sub_q   <= sub_d;
    nb_q    <= nb_d;
    nl_q    <= nl_d;
    fresh_q <= fresh_d;
    i_q     <= i_d;
    e_q     <= e_d;
    e_end_q <= e_end_d;
    q_q     <= q_d;
  end

  always_ff @(posedge clk_i) begin
    if (ext_we) begin
      ext_mem[ext_wa] <= ext_wd;
    end
    ext_rd_q <= ext_mem[ext_ra];
  end

  always_ff @(posedge clk_i) begin
    if (mark_we) begin
      mark_mem[mark_wa] <= mark_wd;
    end
    mark_rd_q <= mark_mem[mark_ra];
  end

  assign rd_req_o = '{nbr_addr: nbr_ra, rng_addr: rng_ra};

  assign stat_o.idle      = (state_q == ST_IDLE);
  assign stat_o.done      = (state_q == ST_DONE);
  assign stat_o.total     = cnt_q[CNT_W] ? '1 : cnt_q[CNT_W-1:0];
  assign stat_o.saturated = cnt_q[CNT_W];

endmodule

/* rtl/core/esu_subgraph_count.sv */
// Top level of the connected induced subgraph counter.
// Load beats are taken one per cycle while the store and the search are idle and
// fill the adjacency store; a start beat then holds the request channel low for
// the whole search, which is sequenced over memories with one read and one write
// port each: adjacency entries are scanned for candidates, entries are marked or
// unmarked around the subgraph and its vertices in each marking pass, candidates
// are carried over and tried, levels are left, and every vertex id is swept as
// root. The search result waits in an output register, while further load beats
// are still accepted. After reset a clearing pass over all 4096 vertex entries
// runs before the first request beat is taken; size writes are taken at any time
// and apply to the next start.
module esu_subgraph_count (
  input  logic clk_i,
  input  logic rst_ni,
  esc_req_if.sink   req,
  esc_res_if.source res,
  esc_cfg_if.sink   cfg
);
  import esc_pkg::*;

  logic [SIZE_W-1:0] size_q, size_d;
  logic              res_valid_q, res_valid_d;
  logic [CNT_W-1:0]  total_q;
  logic              sat_q;
  logic              store_ready, req_acc, slot_free;
  search_stat_t      stat;
  rd_req_t           rd_req;
  rd_rsp_t           rd_rsp;

  assign req.ready = store_ready && stat.idle;
  assign req_acc   = req.valid && req.ready;
  assign cfg.ready = 1'b1;
  assign slot_free = !res_valid_q || res.ready;

  esc_graph_store u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ld_valid_i  (req_acc && (req.req_type == REQ_LOAD)),
    .ld_vertex_i (req.vertex_id),
    .ld_nbr_i    (req.neighbour_id),
    .ready_o     (store_ready),
    .rd_req_i    (rd_req),
    .rd_rsp_o    (rd_rsp)
  );

  esc_search u_search (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (req_acc && (req.req_type == REQ_START)),
    .size_i      (size_q),
    .slot_free_i (slot_free),
    .stat_o      (stat),
    .rd_req_o    (rd_req),
    .rd_rsp_i    (rd_rsp)
  );

  always_comb begin
    size_d      = size_q;
    res_valid_d = res_valid_q;
    if (cfg.valid) begin
      size_d = cfg.subgraph_size;
    end
    if (stat.done && slot_free) begin
      res_valid_d = 1'b1;
    end else if (res.ready) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q      <= SIZE_RESET;
      res_valid_q <= 1'b0;
    end else begin
      size_q      <= size_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stat.done && slot_free) begin
      total_q <= stat.total;
      sat_q   <= stat.saturated;
    end
  end

  assign res.valid       = res_valid_q;
  assign res.motif_total = total_q;
  assign res.saturated   = sat_q;

endmodule

/* test/tb_top.sv */
// Self-checking testbench of the connected induced subgraph counter.
`timescale 1ns / 1ps

class esc_scoreboard;
  typedef struct {
    logic [esc_pkg::CNT_W-1:0] total;
    logic                      saturated;
  } count_t;

  localparam int unsigned NV = esc_pkg::MAX_VERTICES;
  localparam int unsigned NE = esc_pkg::MAX_EDGES;
  localparam int unsigned NS = esc_pkg::MAX_SUBGRAPH;
  localparam longint unsigned COUNT_CAP = 64'hFFFF_FFFF;

  int unsigned nbr_list[NE];
  int unsigned first_entry[NV+1];
  bit          near_mark[NV];
  int unsigned cand_stack[NE];
  int unsigned members[NS];
  longint unsigned tally;
  logic [esc_pkg::SIZE_W-1:0] size_reg;
  count_t counts_due[$];
  int errors;

  function new();
    foreach (first_entry[i]) first_entry[i] = 0;
    foreach (near_mark[i]) near_mark[i] = 0;
    size_reg = esc_pkg::SIZE_RESET;
    tally = 0;
    errors = 0;
  endfunction

  function void set_size(logic [esc_pkg::SIZE_W-1:0] val);
    size_reg = val;
  endfunction

  function int pending();
    return counts_due.size();
  endfunction

  function void mark_closed(int unsigned v, bit val);
    near_mark[v] = val;
    for (int unsigned e = first_entry[v]; e < first_entry[v+1]; e++)
      near_mark[nbr_list[e]] = val;
  endfunction

  function void grow_from(int unsigned root, int unsigned k);
    int unsigned base[NS];
    int unsigned len[NS];
    int unsigned rem[NS];
    int unsigned f, w, s, nb, nl, fresh, u;
    f = 0;
    len[0] = 0;
    for (int unsigned e = first_entry[root]; e < first_entry[root+1]; e++) begin
      u = nbr_list[e];
      if (u > root && !near_mark[u] && len[0] < NE) begin
        cand_stack[len[0]] = u;
        len[0]++;
        near_mark[u] = 1;
      end
    end
    for (int unsigned q = 0; q < len[0]; q++) near_mark[cand_stack[q]] = 0;
    base[0] = 0;
    rem[0] = len[0];
    members[0] = root;
    forever begin
      if (rem[f] == 0) begin
        if (f == 0) break;
        f--;
        continue;
      end
      rem[f]--;
      w = cand_stack[base[f] + rem[f]];
      s = f + 1;
      members[s] = w;
      if (s + 1 == k) begin
        tally++;
        if (tally > COUNT_CAP) return;
        continue;
      end
      nb = base[f] + len[f];
      nl = 0;
      for (int unsigned i = 0; i < rem[f]; i++)
        if (nb + nl < NE) begin
          cand_stack[nb + nl] = cand_stack[base[f] + i];
          nl++;
        end
      for (int unsigned i = 0; i < s; i++) mark_closed(members[i], 1);
      fresh = nb + nl;
      for (int unsigned e = first_entry[w]; e < first_entry[w+1]; e++) begin
        u = nbr_list[e];
        if (u > root && !near_mark[u] && nb + nl < NE) begin
          cand_stack[nb + nl] = u;
          nl++;
          near_mark[u] = 1;
        end
      end
      for (int unsigned i = 0; i < s; i++) mark_closed(members[i], 0);
      for (int unsigned q = fresh; q < nb + nl; q++) near_mark[cand_stack[q]] = 0;
      f++;
      base[f] = nb;
      len[f] = nl;
      rem[f] = nl;
    end
  endfunction

  function void note_beat(logic kind, esc_pkg::vid_t v, esc_pkg::vid_t n);
    int unsigned stored, k;
    count_t c;
    if (kind == esc_pkg::REQ_LOAD) begin
      stored = first_entry[NV];
      if (stored >= NE || first_entry[int'(v) + 1] != stored) return;
      nbr_list[stored] = n;
      for (int unsigned x = int'(v) + 1; x <= NV; x++) first_entry[x]++;
      return;
    end
    k = size_reg;
    if (k < 2) k = 2;
    if (k > NS) k = NS;
    tally = 0;
    for (int unsigned x = 0; x < NV && tally <= COUNT_CAP; x++)
      if (first_entry[x+1] > first_entry[x]) grow_from(x, k);
    if (tally > COUNT_CAP) begin
      c.total = '1;
      c.saturated = 1'b1;
    end else begin
      c.total = tally[esc_pkg::CNT_W-1:0];
      c.saturated = 1'b0;
    end
    counts_due.insert(counts_due.size(), c);
  endfunction

  task report(string what);
    $display("error: %s", what);
    errors++;
  endtask

  task check_count(logic [esc_pkg::CNT_W-1:0] total, logic saturated);
    count_t c;
    if (counts_due.size() == 0) begin
      report($sformatf("unexpected result total=%0d", total));
      return;
    end
    c = counts_due.pop_front();
    if (total !== c.total)
      report($sformatf("motif_total %0d, expected %0d", total, c.total));
    if (saturated !== c.saturated)
      report($sformatf("saturated %0b, expected %0b", saturated, c.saturated));
  endtask
endclass

module tb_top;
  import esc_pkg::*;

  logic clk_i;
  logic rst_ni;
  logic req_fire, res_fire, cfg_fire;
  bit   no_gaps;
  int   beats_sent;
  int   base_id;
  esc_scoreboard sb;

  esc_req_if req_bus();
  esc_res_if res_bus();
  esc_cfg_if cfg_bus();

  esu_subgraph_count uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req   (req_bus),
    .res   (res_bus),
    .cfg   (cfg_bus)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #400_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  always @(negedge clk_i) begin
    req_fire <= req_bus.valid && req_bus.ready;
    res_fire <= res_bus.valid && res_bus.ready;
    cfg_fire <= cfg_bus.valid && cfg_bus.ready;
    if (rst_ni && req_bus.valid && req_bus.ready)
      sb.note_beat(req_bus.req_type, req_bus.vertex_id, req_bus.neighbour_id);
    if (rst_ni && cfg_bus.valid && cfg_bus.ready)
      sb.set_size(cfg_bus.subgraph_size);
    if (rst_ni && res_bus.valid && res_bus.ready)
      sb.check_count(res_bus.motif_total, res_bus.saturated);
  end

  int stall_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_bus.ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      res_bus.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      res_bus.ready <= 1'b1;
      stall_left <= gap_len();
    end
  end

  task automatic send_req(logic kind, int v, int n);
    int g;
    g = gap_len();
    if (g > 0) begin
      req_bus.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    req_bus.valid <= 1'b1;
    req_bus.req_type <= kind;
    req_bus.vertex_id <= vid_t'(v);
    req_bus.neighbour_id <= vid_t'(n);
    do @(posedge clk_i); while (!req_fire);
    beats_sent++;
  endtask

  task automatic load(int v, int n);
    send_req(REQ_LOAD, v, n);
  endtask

  task automatic write_size(int val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.subgraph_size <= SIZE_W'(val);
    do @(posedge clk_i); while (!cfg_fire);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic count_and_drain(bit twice);
    send_req(REQ_START, $urandom_range(0, 4095), $urandom_range(0, 4095));
    if (twice) send_req(REQ_START, $urandom_range(0, 4095), $urandom_range(0, 4095));
    req_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic load_cluster(int first, int n);
    bit adj[6][6];
    int row[$];
    int j, t, deg;
    foreach (adj[a, b]) adj[a][b] = 0;
    for (int a = 0; a < n; a++)
      for (int b = a + 1; b < n; b++)
        if ($urandom_range(0, 1)) begin
          adj[a][b] = 1;
          adj[b][a] = 1;
        end
    for (int a = 0; a < n; a++) begin
      deg = 0;
      for (int b = 0; b < n; b++) deg += adj[a][b];
      if (deg == 0) begin
        j = (a + $urandom_range(1, n - 1)) % n;
        adj[a][j] = 1;
        adj[j][a] = 1;
      end
    end
    for (int a = 0; a < n; a++) begin
      row.delete();
      for (int b = 0; b < n; b++) if (adj[a][b]) row.insert(row.size(), first + b);
      for (int i = row.size() - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        t = row[i];
        row[i] = row[j];
        row[j] = t;
      end
      foreach (row[i]) load(first + a, row[i]);
      case ($urandom_range(0, 19))
        0: load(first + a, first + a);
        1: load(first + a, row[0]);
        2: if (first > 0) load(first + a, $urandom_range(0, first - 1));
        3: if (first > 0) load($urandom_range(0, first - 1), $urandom_range(0, 4095));
        4: if ($urandom_range(0, 3) == 0) load(first + a, $urandom_range(first, 4095));
        default: ;
      endcase
    end
  endtask

  initial begin
    int sizes[5];
    sizes = '{0, 1, 3, 8, 15};
    rst_ni = 1'b0;
    req_bus.valid = 1'b0;
    req_bus.req_type = REQ_LOAD;
    req_bus.vertex_id = '0;
    req_bus.neighbour_id = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.subgraph_size = '0;
    no_gaps = 0;
    beats_sent = 0;
    sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_size(2);
    load(0, 1);
    load(0, 2);
    load(0, 0);
    load(0, 1);
    load(1, 0);
    load(1, 2);
    load(2, 0);
    load(2, 1);
    load(2, 4095);
    load(1, 3);
    load(3, 2);
    count_and_drain(0);
    foreach (sizes[i]) begin
      write_size(sizes[i]);
      count_and_drain(i == 2);
    end

    base_id = 4;
    while (beats_sent < 480 && base_id < 3900) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 3) == 0) write_size($urandom_range(0, 1) ? 2 : 8);
      else write_size($urandom_range(0, 15));
      load_cluster(base_id, $urandom_range(3, 6));
      count_and_drain($urandom_range(0, 9) == 0);
      base_id += 6 + $urandom_range(1, 90);
    end
    no_gaps = 0;
    write_size(8);
    load_cluster(4090, 6);
    count_and_drain(0);
    write_size(15);
    count_and_drain(0);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

/* sim.f */
rtl/core/esc_pkg.sv
rtl/core/esc_if.sv
rtl/core/esc_graph_store.sv
rtl/core/esc_search.sv
rtl/core/esu_subgraph_count.sv
test/tb_top.sv
